### rtl/ftp_pkg.sv
// Shared types and constants for the fraction text parser.
// No dependencies; imported by fraction_text_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

package ftp_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int NUMER_BITS     = VALUE_BITS - 1;
  localparam int CH_BITS        = 8;
  localparam int DIGIT_BITS     = 4;
  localparam int KIND_BITS      = 2;
  localparam int OUT_DATA_BITS  = ((NUMER_BITS + VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS   = OUT_DATA_BITS - NUMER_BITS - VALUE_BITS;

  localparam logic [CH_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_BITS-1:0] CH_SLASH = 8'h2f;
  localparam logic [CH_BITS-1:0] CH_BSL   = 8'h5c;
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_BITS-1:0] CH_CR    = 8'h0d;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_DEFAULT  = 2'd0,
    KIND_NUMER    = 2'd1,
    KIND_FRACTION = 2'd2
  } kind_t;

  typedef enum logic [7:0] {
    PH_START   = 8'b0000_0001,
    PH_NUMER   = 8'b0000_0010,
    PH_SEP     = 8'b0000_0100,
    PH_DWS     = 8'b0000_1000,
    PH_DSIGN   = 8'b0001_0000,
    PH_DDIGIT  = 8'b0010_0000,
    PH_DDONE   = 8'b0100_0000,
    PH_INVALID = 8'b1000_0000
  } phase_t;

endpackage

`default_nettype wire

### rtl/fraction_text_parser_unit.sv
// Fraction text parser: byte stream in, one numerator/denominator item per string.
// Depends on ftp_pkg for widths, character codes, phase and kind types.
`timescale 1ns / 1ps
`default_nettype none

// Takes one text byte per cycle on the slave side; a zero byte ends the string and
// yields one item on the master side in the next cycle, with the parser back at the
// start of a new string. A byte is taken every cycle unless a finished item is held
// in the output register and not yet taken. Each byte does one phase step; a digit
// of the numerator or denominator also does one saturating multiply-by-ten accumulate.
// kind 0 gives 0/1, kind 1 gives n/1, kind 2 gives n/d with a zero denominator reported as 1.
module fraction_text_parser_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [ftp_pkg::CH_BITS-1:0]       s_tdata,  // ch
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [ftp_pkg::OUT_DATA_BITS-1:0]      m_tdata,  // numer, denom, zero pad
  output logic [ftp_pkg::KIND_BITS-1:0]          m_tuser   // kind
);
  import ftp_pkg::*;

  localparam logic [NUMER_BITS-1:0] NUMER_LIMIT = {NUMER_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0] POS_LIMIT   = {1'b0, {NUMER_BITS{1'b1}}};
  localparam logic [VALUE_BITS-1:0] NEG_LIMIT   = {1'b1, {NUMER_BITS{1'b0}}};

  phase_t                  phase, phase_next;
  logic [NUMER_BITS-1:0]   numer_acc, numer_acc_next;
  logic [VALUE_BITS-1:0]   denom_acc, denom_acc_next;
  logic                    denom_negative, denom_negative_next;

  logic [NUMER_BITS-1:0]   numer_out;
  logic [VALUE_BITS-1:0]   denom_out;
  kind_t                   kind_out, kind_q;
  logic [NUMER_BITS-1:0]   numer_q;
  logic [VALUE_BITS-1:0]   denom_q;

  logic                    accept, is_end, is_digit, is_sep, is_space, is_sign;
  logic [DIGIT_BITS-1:0]   digit;
  logic [NUMER_BITS+3:0]   numer_mac;
  logic [VALUE_BITS+3:0]   denom_mac;
  logic [VALUE_BITS-1:0]   denom_limit;
  logic [NUMER_BITS-1:0]   numer_sat;
  logic [VALUE_BITS-1:0]   denom_sat;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_end   = (s_tdata == CH_NUL);
  assign is_digit = s_tdata inside {[CH_ZERO:CH_NINE]};
  assign is_sep   = (s_tdata == CH_SLASH) || (s_tdata == CH_BSL);
  assign is_space = (s_tdata == CH_SPACE) || (s_tdata inside {[CH_TAB:CH_CR]});
  assign is_sign  = (s_tdata == CH_PLUS) || (s_tdata == CH_MINUS);
  assign digit    = DIGIT_BITS'(s_tdata - CH_ZERO);

  assign numer_mac   = {1'b0, numer_acc, 3'b000} + {3'b000, numer_acc, 1'b0}
                       + {{NUMER_BITS{1'b0}}, digit};
  assign numer_sat   = (numer_mac > {4'b0000, NUMER_LIMIT}) ? NUMER_LIMIT
                                                            : numer_mac[NUMER_BITS-1:0];
  assign denom_limit = denom_negative ? NEG_LIMIT : POS_LIMIT;
  assign denom_mac   = {1'b0, denom_acc, 3'b000} + {3'b000, denom_acc, 1'b0}
                       + {{VALUE_BITS{1'b0}}, digit};
  assign denom_sat   = (denom_mac > {4'b0000, denom_limit}) ? denom_limit
                                                            : denom_mac[VALUE_BITS-1:0];

  always_comb begin
    phase_next          = phase;
    numer_acc_next      = numer_acc;
    denom_acc_next      = denom_acc;
    denom_negative_next = denom_negative;
    if (is_end) begin
      phase_next          = PH_START;
      numer_acc_next      = '0;
      denom_acc_next      = '0;
      denom_negative_next = 1'b0;
    end else begin
      case (phase)
        PH_START: begin
          if (is_digit) begin
            numer_acc_next = numer_sat;
            phase_next     = PH_NUMER;
          end else begin
            phase_next = PH_INVALID;
          end
        end
        PH_NUMER: begin
          if (is_digit) begin
            numer_acc_next = numer_sat;
          end else if (is_sep) begin
            phase_next = PH_SEP;
          end else begin
            phase_next = PH_INVALID;
          end
        end
        PH_SEP, PH_DWS: begin
          if (phase == PH_SEP && is_sep) begin
            phase_next = PH_SEP;
          end else if (is_space) begin
            phase_next = PH_DWS;
          end else if (is_sign) begin
            denom_negative_next = (s_tdata == CH_MINUS);
            phase_next          = PH_DSIGN;
          end else if (is_digit) begin
            denom_acc_next = denom_sat;
            phase_next     = PH_DDIGIT;
          end else begin
            phase_next = PH_DDONE;
          end
        end
        PH_DSIGN, PH_DDIGIT: begin
          if (is_digit) begin
            denom_acc_next = denom_sat;
            phase_next     = PH_DDIGIT;
          end else begin
            phase_next = PH_DDONE;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_comb begin
    kind_out  = KIND_DEFAULT;
    numer_out = '0;
    denom_out = VALUE_BITS'(1);
    case (phase)
      PH_NUMER, PH_SEP: begin
        kind_out  = KIND_NUMER;
        numer_out = numer_acc;
      end
      PH_DWS, PH_DSIGN, PH_DDIGIT, PH_DDONE: begin
        kind_out  = KIND_FRACTION;
        numer_out = numer_acc;
        if (denom_acc != '0) begin
          denom_out = denom_negative ? VALUE_BITS'(~denom_acc + 1'b1) : denom_acc;
        end
      end
      default: begin
        kind_out = KIND_DEFAULT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      numer_acc      <= '0;
      denom_acc      <= '0;
      denom_negative <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      numer_acc      <= numer_acc_next;
      denom_acc      <= denom_acc_next;
      denom_negative <= denom_negative_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && is_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_end) begin
      kind_q  <= kind_out;
      numer_q <= numer_out;
      denom_q <= denom_out;
    end
  end

  assign m_tdata = {{OUT_PAD_BITS{1'b0}}, denom_q, numer_q};
  assign m_tuser = kind_q;

  a_end_gives_item: assert property (@(posedge clk) disable iff (rst)
    accept && is_end |=> m_tvalid && phase == PH_START)
    else $error("terminator did not produce an item");

  a_denom_range: assert property (@(posedge clk) disable iff (rst)
    denom_acc <= NEG_LIMIT && (denom_negative || denom_acc <= POS_LIMIT))
    else $error("denominator accumulator out of range");

  a_sign_phase: assert property (@(posedge clk) disable iff (rst)
    denom_negative |-> phase == PH_DSIGN || phase == PH_DDIGIT || phase == PH_DDONE)
    else $error("sign set outside denominator phases");

  a_default_item: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && kind_q == KIND_DEFAULT |-> numer_q == '0 && denom_q == VALUE_BITS'(1))
    else $error("default item is not 0/1");

endmodule

`default_nettype wire
